@@ design/qs_pkg.sv @@
// ----------------------------------------------------------------------------
// qs_pkg: shared types and constants of the quickscore posterior engine
// Command codes, queue entry, configuration and result structs, and the
// state encoding of the back-end sequencer.
// ----------------------------------------------------------------------------
package qs_pkg;

    // Q1.31 one
    localparam logic [31:0] ONE_Q31 = 32'h8000_0000;

    // depth of the command queue between front and back end
    localparam int QDEPTH = 4;

    // configuration register indexes
    localparam logic CFG_NUM_DISEASES = 1'b0;
    localparam logic CFG_NUM_FINDINGS = 1'b1;

    // command codes; codes 6 and 7 mean nothing and are dropped by the front end
    typedef enum logic [2:0] {
        OP_INHIBIT = 3'd0,
        OP_PRIOR   = 3'd1,
        OP_LEAK    = 3'd2,
        OP_POS     = 3'd3,
        OP_NEG     = 3'd4,
        OP_START   = 3'd5
    } op_t;

    // classified command as it travels through the queue
    typedef struct packed {
        op_t         op;
        logic [5:0]  finding;
        logic [4:0]  disease;
        logic [31:0] value;     // already clamped to one
    } cmd_t;

    typedef struct packed {
        logic [5:0] num_diseases;
        logic [6:0] num_findings;
    } cfg_t;

    typedef struct packed {
        logic [4:0]  disease;
        logic [31:0] posterior;
        logic        degenerate;
        logic        last;
    } result_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SCAN,
        S_MASK,
        S_PROD,
        S_TERM,
        S_TERM2,
        S_TERM3,
        S_BRD,
        S_B1,
        S_B2,
        S_B3,
        S_FRD,
        S_FA,
        S_FM1,
        S_FM2,
        S_FM3,
        S_FT,
        S_FD,
        S_DIV,
        S_OUT
    } eng_state_t;

endpackage

@@ design/qs_front.sv @@
// ----------------------------------------------------------------------------
// qs_front: input front end
// Takes input beats, unpacks and classifies them, clamps the probability to
// one and pushes known commands into the queue. Unknown codes are dropped.
// ----------------------------------------------------------------------------
module qs_front (
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [47:0]   s_tdata,   // finding[5:0], disease[10:6], value[42:11]
    input  logic [2:0]    s_tuser,   // func[2:0]
    input  logic          q_full,
    output logic          q_push,
    output qs_pkg::cmd_t  q_cmd
);
    import qs_pkg::*;

    logic [31:0] raw_value;
    logic        known;

    assign s_tready = !q_full;

    // unpack and clamp
    assign raw_value       = s_tdata[42:11];
    assign q_cmd.op        = op_t'(s_tuser);
    assign q_cmd.finding   = s_tdata[5:0];
    assign q_cmd.disease   = s_tdata[10:6];
    assign q_cmd.value     = (raw_value > ONE_Q31) ? ONE_Q31 : raw_value;

    // only defined codes go on to the back end
    assign known  = (s_tuser <= OP_START);
    assign q_push = s_tvalid && !q_full && known;

endmodule

@@ design/qs_fifo.sv @@
// ----------------------------------------------------------------------------
// qs_fifo: command queue
// Short queue that decouples the front end from the back-end sequencer.
// ----------------------------------------------------------------------------
module qs_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  qs_pkg::cmd_t  din,
    input  logic          pop,
    output qs_pkg::cmd_t  dout,
    output logic          full,
    output logic          empty
);
    import qs_pkg::*;

    localparam int QAW = $clog2(QDEPTH);

    cmd_t             mem_reg [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg;
    logic [QAW-1:0]   rd_ptr_reg;
    logic [QAW:0]     count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == (QAW+1)'(QDEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)      count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push) count_reg <= count_reg - 1'b1;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) mem_reg[wr_ptr_reg] <= din;
    end

endmodule

@@ design/qs_engine.sv @@
// ----------------------------------------------------------------------------
// qs_engine: back-end sequencer
// Executes load commands into the stores and, on start, walks every subset
// of the positive findings with Q1.31 multipliers, builds the
// leave-one-out terms, accumulates them and emits normalized posteriors.
// ----------------------------------------------------------------------------
module qs_engine #(
    parameter int MAX_DISEASES = 32,
    parameter int MAX_FINDINGS = 64,
    parameter int MAX_POSITIVE = 12
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  qs_pkg::cfg_t     cfg,
    input  logic             q_empty,
    input  qs_pkg::cmd_t     q_cmd,
    output logic             q_pop,
    output logic             m_valid,
    input  logic             m_ready,
    output qs_pkg::result_t  m_item
);
    import qs_pkg::*;

    localparam int FW    = (MAX_FINDINGS > 1) ? $clog2(MAX_FINDINGS) : 1;
    localparam int NFW   = $clog2(MAX_FINDINGS + 1);
    localparam int DIW   = (MAX_DISEASES > 1) ? $clog2(MAX_DISEASES) : 1;
    localparam int DW    = $clog2(MAX_DISEASES + 1);
    localparam int NTERM = MAX_DISEASES + 1;
    localparam int IDEP  = MAX_DISEASES * MAX_FINDINGS;
    localparam int AW    = (IDEP > 1) ? $clog2(IDEP) : 1;
    localparam int PCW   = $clog2(MAX_POSITIVE + 1);
    localparam int PIW   = (MAX_POSITIVE > 1) ? $clog2(MAX_POSITIVE) : 1;
    localparam int SIW   = MAX_POSITIVE + 1;

    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

    // Q1.31 product, rounded
    function automatic logic [31:0] mulq31(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = {32'd0, a} * {32'd0, b};
        p = p + 64'h4000_0000;
        return p[62:31];
    endfunction

    // saturating signed add
    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
        return s[63:0];
    endfunction

    // combine split products of a scaled accumulator, round, saturate, sign
    function automatic logic signed [63:0] scale_fin(input logic [63:0] hi,
                                                     input logic [63:0] lo,
                                                     input logic neg);
        logic [64:0] l;
        logic [64:0] r;
        l = {1'b0, lo} + 65'h4000_0000;
        r = {hi, 1'b0} + (l >> 31);
        if (r > 65'h0_7FFF_FFFF_FFFF_FFFF) return neg ? S64_MIN : S64_MAX;
        return neg ? -r[63:0] : r[63:0];
    endfunction

    // ------------------------------------------------------------------
    // storage
    // ------------------------------------------------------------------
    logic [31:0]        inh_mem   [IDEP];
    logic [31:0]        prior_mem [MAX_DISEASES];
    logic [31:0]        leak_mem  [MAX_FINDINGS];
    logic [31:0]        pt_mem    [NTERM];
    logic [31:0]        pre_mem   [NTERM];
    logic [31:0]        on_mem    [NTERM];
    logic signed [63:0] aoff_mem  [MAX_DISEASES];
    logic signed [63:0] aon_mem   [MAX_DISEASES];

    logic [31:0]        inh_q, leak_q, prior_q, pt_q, pre_q, on_q;
    logic signed [63:0] aoff_q, aon_q;

    // control and datapath registers
    eng_state_t         state_reg, state_next;
    logic [5:0]         poslist_reg [MAX_POSITIVE];
    logic [PCW-1:0]     pcount_reg;
    logic [MAX_FINDINGS-1:0] negmask_reg;
    logic [5:0]         pos_reg [MAX_POSITIVE];
    logic [PCW-1:0]     np_reg, i_reg;
    logic [SIW-1:0]     si_reg;
    logic [MAX_FINDINGS-1:0] fm_reg, fm_new;
    logic               par_reg;
    logic [DW-1:0]      d_reg;
    logic [NFW-1:0]     f_reg;
    logic               rv_reg, mbit_reg;
    logic [31:0]        on_reg, prod_reg, pt_reg, pre_reg, suf_reg, myp_reg, ton_reg;
    logic [63:0]        abs_off_reg, abs_on_reg;
    logic               neg_off_reg, neg_on_reg;
    logic [31:0]        pon_f_reg, qoff_reg;
    logic [63:0]        hi_reg, lo_reg;
    logic signed [63:0] po_reg, pn_reg, tot_reg;
    logic [63:0]        rem_reg;
    logic [31:0]        quo_reg, post_reg;
    logic [4:0]         cnt_reg;
    logic               deg_reg;
    logic               m_valid_reg;
    result_t            m_item_reg;

    // derived control
    logic [DW-1:0]      nd;
    logic [NFW-1:0]     nf;
    logic [DIW-1:0]     ai;
    logic [AW-1:0]      inh_raddr, inh_waddr;
    logic [31:0]        pon, mul_op, pt_clamp;
    logic [32:0]        pt_sum;
    logic               last_sub, out_free, first_sub;
    logic signed [63:0] toff_term, ton_term;
    logic [64:0]        div_r2;
    logic               div_ge;

    // effective counts, saturated into range
    always_comb begin
        if (cfg.num_diseases == '0)                    nd = DW'(1);
        else if (int'(cfg.num_diseases) > MAX_DISEASES) nd = DW'(MAX_DISEASES);
        else                                            nd = DW'(cfg.num_diseases);
        if (cfg.num_findings == '0)                    nf = NFW'(1);
        else if (int'(cfg.num_findings) > MAX_FINDINGS) nf = NFW'(MAX_FINDINGS);
        else                                            nf = NFW'(cfg.num_findings);
    end

    assign ai        = DIW'(d_reg - DW'(1));
    assign inh_raddr = AW'((int'(d_reg) - 1) * MAX_FINDINGS + int'(f_reg[FW-1:0]));
    assign inh_waddr = AW'(int'(q_cmd.disease) * MAX_FINDINGS + int'(q_cmd.finding));
    assign pon       = (d_reg == '0) ? ONE_Q31 : prior_q;
    assign mul_op    = mbit_reg ? ((d_reg == '0) ? leak_q : inh_q) : ONE_Q31;
    assign pt_sum    = {1'b0, ONE_Q31 - pon} + {1'b0, prod_reg};
    assign pt_clamp  = (pt_sum > {1'b0, ONE_Q31}) ? ONE_Q31 : pt_sum[31:0];
    assign last_sub  = (si_reg == ((SIW'(1) << np_reg) - SIW'(1)));
    assign first_sub = (si_reg == '0);
    assign out_free  = !m_valid_reg || m_ready;

    // leave-one-out terms in Q16.48, signed by subset size
    assign toff_term = par_reg ? -$signed({15'd0, myp_reg, 17'd0})
                               :  $signed({15'd0, myp_reg, 17'd0});
    assign ton_term  = par_reg ? -$signed({15'd0, ton_reg, 17'd0})
                               :  $signed({15'd0, ton_reg, 17'd0});

    // one restoring division step
    assign div_r2 = {rem_reg, 1'b0};
    assign div_ge = (div_r2 >= {1'b0, tot_reg});

    // finding mask of the current subset
    always_comb begin
        fm_new = negmask_reg;
        for (int i = 0; i < MAX_POSITIVE; i++) begin
            if (i < int'(np_reg)) begin
                if (si_reg[int'(np_reg) - 1 - i]) fm_new[FW'(pos_reg[i])] = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else          state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        q_pop      = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (!q_empty) begin
                    q_pop = 1'b1;
                    if (q_cmd.op == OP_START) state_next = S_SCAN;
                end
            end
            S_SCAN:  if (i_reg == pcount_reg) state_next = S_MASK;
            S_MASK:  state_next = S_PROD;
            S_PROD:  if (f_reg == nf && !rv_reg) state_next = S_TERM;
            S_TERM:  state_next = S_TERM2;
            S_TERM2: state_next = S_TERM3;
            S_TERM3: state_next = (d_reg == nd) ? S_BRD : S_PROD;
            S_BRD:   state_next = S_B1;
            S_B1:    state_next = S_B2;
            S_B2:    state_next = S_B3;
            S_B3: begin
                if (d_reg == DW'(1)) state_next = last_sub ? S_FRD : S_MASK;
                else                 state_next = S_BRD;
            end
            S_FRD:   state_next = S_FA;
            S_FA:    state_next = S_FM1;
            S_FM1:   state_next = S_FM2;
            S_FM2:   state_next = S_FM3;
            S_FM3:   state_next = S_FT;
            S_FT:    state_next = S_FD;
            S_FD: begin
                if (tot_reg <= 64'sd0 || pn_reg >= tot_reg || pn_reg <= 64'sd0)
                    state_next = S_OUT;
                else
                    state_next = S_DIV;
            end
            S_DIV:   if (cnt_reg == 5'd30) state_next = S_OUT;
            S_OUT: begin
                if (out_free) state_next = (d_reg == nd) ? S_IDLE : S_FRD;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // memories: load writes, per-step reads
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && !q_empty) begin
            unique case (q_cmd.op)
                OP_INHIBIT: begin
                    if (int'(q_cmd.finding) < MAX_FINDINGS && int'(q_cmd.disease) < MAX_DISEASES)
                        inh_mem[inh_waddr] <= q_cmd.value;
                end
                OP_PRIOR: begin
                    if (int'(q_cmd.disease) < MAX_DISEASES)
                        prior_mem[DIW'(q_cmd.disease)] <= q_cmd.value;
                end
                OP_LEAK: begin
                    if (int'(q_cmd.finding) < MAX_FINDINGS)
                        leak_mem[FW'(q_cmd.finding)] <= q_cmd.value;
                end
                OP_POS, OP_NEG, OP_START: ;
                default: ;
            endcase
        end
        inh_q   <= inh_mem[inh_raddr];
        leak_q  <= leak_mem[f_reg[FW-1:0]];
        prior_q <= prior_mem[ai];
    end

    // per-disease subset terms
    always_ff @(posedge aclk) begin
        if (state_reg == S_TERM2) on_mem[d_reg] <= on_reg;
        if (state_reg == S_TERM3) begin
            pt_mem[d_reg]  <= pt_reg;
            pre_mem[d_reg] <= pre_reg;
        end
        pt_q  <= pt_mem[d_reg];
        pre_q <= pre_mem[d_reg];
        on_q  <= on_mem[d_reg];
    end

    // accumulators; the first subset overwrites
    always_ff @(posedge aclk) begin
        if (state_reg == S_B3) begin
            aoff_mem[ai] <= first_sub ? toff_term : sat_add(aoff_q, toff_term);
            aon_mem[ai]  <= first_sub ? ton_term  : sat_add(aon_q, ton_term);
        end
        aoff_q <= aoff_mem[ai];
        aon_q  <= aon_mem[ai];
    end

    // ------------------------------------------------------------------
    // finding lists and counts
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pcount_reg  <= '0;
            negmask_reg <= '0;
        end else begin
            if (state_reg == S_IDLE && !q_empty) begin
                if (q_cmd.op == OP_POS && int'(pcount_reg) < MAX_POSITIVE) begin
                    poslist_reg[pcount_reg[PIW-1:0]] <= q_cmd.finding;
                    pcount_reg <= pcount_reg + 1'b1;
                end
                if (q_cmd.op == OP_NEG && int'(q_cmd.finding) < MAX_FINDINGS)
                    negmask_reg[FW'(q_cmd.finding)] <= 1'b1;
            end
            // run done: forget the findings
            if (state_reg == S_OUT && out_free && d_reg == nd) begin
                pcount_reg  <= '0;
                negmask_reg <= '0;
            end
        end
    end

    // ------------------------------------------------------------------
    // datapath
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                i_reg  <= '0;
                np_reg <= '0;
                si_reg <= '0;
            end
            // keep positives that fall inside the finding range
            S_SCAN: begin
                if (i_reg != pcount_reg) begin
                    if (int'(poslist_reg[i_reg[PIW-1:0]]) < int'(nf)) begin
                        pos_reg[np_reg[PIW-1:0]] <= poslist_reg[i_reg[PIW-1:0]];
                        np_reg <= np_reg + 1'b1;
                    end
                    i_reg <= i_reg + 1'b1;
                end
            end
            S_MASK: begin
                fm_reg  <= fm_new;
                par_reg <= ^si_reg;
                d_reg   <= '0;
                f_reg   <= '0;
                rv_reg  <= 1'b0;
                on_reg  <= ONE_Q31;
                pre_reg <= ONE_Q31;
            end
            // product over findings, one per cycle; unmasked ones multiply by one
            S_PROD: begin
                if (f_reg != nf) begin
                    f_reg    <= f_reg + 1'b1;
                    rv_reg   <= 1'b1;
                    mbit_reg <= fm_reg[f_reg[FW-1:0]];
                end else begin
                    rv_reg <= 1'b0;
                end
                if (rv_reg) on_reg <= mulq31(on_reg, mul_op);
            end
            S_TERM:  prod_reg <= mulq31(pon, on_reg);
            S_TERM2: pt_reg   <= pt_clamp;
            // prefix product runs along ascending diseases
            S_TERM3: begin
                pre_reg <= mulq31(pre_reg, pt_reg);
                if (d_reg == nd) begin
                    suf_reg <= ONE_Q31;
                end else begin
                    d_reg  <= d_reg + 1'b1;
                    f_reg  <= '0;
                    rv_reg <= 1'b0;
                    on_reg <= ONE_Q31;
                end
            end
            S_BRD: ;
            // suffix product runs along descending diseases
            S_B1: begin
                myp_reg <= mulq31(pre_q, suf_reg);
                suf_reg <= mulq31(suf_reg, pt_q);
            end
            S_B2: ton_reg <= mulq31(myp_reg, on_q);
            S_B3: begin
                if (d_reg == DW'(1)) begin
                    if (last_sub) d_reg <= DW'(1);
                    else          si_reg <= si_reg + 1'b1;
                end else begin
                    d_reg <= d_reg - 1'b1;
                end
            end
            S_FRD: ;
            // final scaling by prior and its complement
            S_FA: begin
                abs_off_reg <= aoff_q[63] ? -aoff_q : aoff_q;
                abs_on_reg  <= aon_q[63]  ? -aon_q  : aon_q;
                neg_off_reg <= aoff_q[63];
                neg_on_reg  <= aon_q[63];
                pon_f_reg   <= prior_q;
                qoff_reg    <= ONE_Q31 - prior_q;
            end
            S_FM1: begin
                hi_reg <= {32'd0, abs_off_reg[63:32]} * {32'd0, qoff_reg};
                lo_reg <= {32'd0, abs_off_reg[31:0]}  * {32'd0, qoff_reg};
            end
            S_FM2: begin
                po_reg <= scale_fin(hi_reg, lo_reg, neg_off_reg);
                hi_reg <= {32'd0, abs_on_reg[63:32]} * {32'd0, pon_f_reg};
                lo_reg <= {32'd0, abs_on_reg[31:0]}  * {32'd0, pon_f_reg};
            end
            S_FM3: pn_reg  <= scale_fin(hi_reg, lo_reg, neg_on_reg);
            S_FT:  tot_reg <= sat_add(po_reg, pn_reg);
            S_FD: begin
                deg_reg  <= (tot_reg <= 64'sd0);
                post_reg <= (tot_reg > 64'sd0 && pn_reg >= tot_reg) ? ONE_Q31 : 32'd0;
                rem_reg  <= pn_reg;
                quo_reg  <= '0;
                cnt_reg  <= '0;
            end
            // quotient one bit a cycle
            S_DIV: begin
                rem_reg <= div_ge ? 64'(div_r2 - {1'b0, tot_reg}) : div_r2[63:0];
                quo_reg <= {quo_reg[30:0], div_ge};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == 5'd30) post_reg <= {quo_reg[30:0], div_ge};
            end
            S_OUT: if (out_free && d_reg != nd) d_reg <= d_reg + 1'b1;
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == S_OUT && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_OUT && out_free) begin
            m_item_reg.disease    <= 5'(d_reg - DW'(1));
            m_item_reg.posterior  <= post_reg;
            m_item_reg.degenerate <= deg_reg;
            m_item_reg.last       <= (d_reg == nd);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

@@ design/noisy_or_posterior_quickscore.sv @@
// ----------------------------------------------------------------------------
// noisy_or_posterior_quickscore: noisy-OR posterior engine
// Exact disease posteriors in a two-layer noisy-OR network by the
// quickscore inclusion-exclusion sum over subsets of the positive findings.
//
//   channel  | direction | tdata / tuser / tlast
//   ---------+-----------+----------------------------------------------
//   s_       | in        | finding, disease, value / func / -
//   m_       | out       | disease_out, posterior / degenerate / last
//   cfg_     | in        | register index, write data
//
// The back end takes load beats from the queue while idle; the front end and a
// four-entry queue take beats while the back end works.
// A start beat runs the subset work, bound by the multiplier in the finding
// loop, then a final pass per disease, with the divider run only where the
// posterior is strictly between zero and one. Results stall in the output
// register. Reset is synchronous; no clearing pass is needed.
// ----------------------------------------------------------------------------
module noisy_or_posterior_quickscore #(
    parameter int MAX_DISEASES = 32,
    parameter int MAX_FINDINGS = 64,
    parameter int MAX_POSITIVE = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,    // finding[5:0], disease[10:6], value[42:11]
    input  logic [2:0]  s_tuser,    // func[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // disease_out[4:0], posterior[36:5]
    output logic        m_tuser,    // degenerate
    output logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [6:0]  cfg_wdata
);
    import qs_pkg::*;

    cfg_t    cfg_reg;
    cmd_t    push_cmd, head_cmd;
    logic    q_push, q_pop, q_full, q_empty;
    result_t item;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.num_diseases <= 6'd32;
            cfg_reg.num_findings <= 7'd64;
        end else if (cfg_wr_en) begin
            if (cfg_addr == CFG_NUM_DISEASES) cfg_reg.num_diseases <= cfg_wdata[5:0];
            if (cfg_addr == CFG_NUM_FINDINGS) cfg_reg.num_findings <= cfg_wdata;
        end
    end

    qs_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    qs_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (push_cmd),
        .pop     (q_pop),
        .dout    (head_cmd),
        .full    (q_full),
        .empty   (q_empty)
    );

    qs_engine #(
        .MAX_DISEASES (MAX_DISEASES),
        .MAX_FINDINGS (MAX_FINDINGS),
        .MAX_POSITIVE (MAX_POSITIVE)
    ) u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_empty (q_empty),
        .q_cmd   (head_cmd),
        .q_pop   (q_pop),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_item  (item)
    );

    // result beat packing
    assign m_tdata = {3'd0, item.posterior, item.disease};
    assign m_tuser = item.degenerate;
    assign m_tlast = item.last;

endmodule
